// ----- rtl/spr_pkg.sv -----
`default_nettype none
// ============================================================================
// Sprite pixel renderer package
// Shared types and codes for the sprite pixel renderer.
// ============================================================================
package spr_pkg;

  localparam int RamAddrWidth = 16;
  localparam int RamDataWidth = 16;
  localparam int PosWidth     = 9;

  // Request opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_DRAW  = 1'b1;

  // Configuration register indexes
  localparam logic REG_H_OFFSET = 1'b0;
  localparam logic REG_V_OFFSET = 1'b1;

  // Rotate and flip modes, attr_word bits 14:12
  localparam logic [2:0] ROT_NONE      = 3'd0;
  localparam logic [2:0] ROT_FLIP_V    = 3'd1;
  localparam logic [2:0] ROT_FLIP_H    = 3'd2;
  localparam logic [2:0] ROT_FLIP_HV   = 3'd3;
  localparam logic [2:0] ROT_SWAP      = 3'd4;
  localparam logic [2:0] ROT_SWAP_V    = 3'd5;
  localparam logic [2:0] ROT_SWAP_H    = 3'd6;
  localparam logic [2:0] ROT_SWAP_HV   = 3'd7;

  // Lowest visible row
  localparam logic [PosWidth-1:0] MinRow = 9'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIXEL,
    ST_COLOUR
  } spr_state_t;

  // Result of the geometry stage for one draw request
  typedef struct packed {
    logic                    visible;
    logic                    palette_mode;
    logic                    spys;
    logic [RamAddrWidth-1:0] vram_addr;
    logic [RamAddrWidth-1:0] fetch_addr;
    logic [11:0]             pal_index;
    logic [1:0]              nibble;
  } spr_geom_t;

endpackage
`default_nettype wire

// ----- rtl/spr_ram.sv -----
`default_nettype none
// ============================================================================
// Sprite RAM
// Single-clock word memory, one write port and one registered read port.
// ============================================================================
module spr_ram
  import spr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [RamAddrWidth-1:0] waddr,
  input  wire logic [RamDataWidth-1:0] wdata,
  input  wire logic                    re,
  input  wire logic [RamAddrWidth-1:0] raddr,
  output      logic [RamDataWidth-1:0] rdata
);

  logic [RamDataWidth-1:0] mem [0:(1 << RamAddrWidth) - 1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/spr_geom.sv -----
`default_nettype none
// ============================================================================
// Sprite geometry
// Offset, rotate, shrink, wrap and clip of one pattern pixel, plus the
// address of the first sprite RAM fetch.
// ============================================================================
module spr_geom
  import spr_pkg::*;
(
  input  wire logic [15:0]         pos_x_word,
  input  wire logic [15:0]         pos_y_word,
  input  wire logic [15:0]         attr_word,
  input  wire logic [15:0]         palette_word,
  input  wire logic [3:0]          pat_x,
  input  wire logic [3:0]          pat_y,
  input  wire logic [PosWidth-1:0] h_offset,
  input  wire logic [PosWidth-1:0] v_offset,
  output      spr_geom_t           geom
);

  logic [PosWidth-1:0] base_x;
  logic [PosWidth-1:0] base_y;
  logic [3:0]          rot_x;
  logic [3:0]          rot_y;
  logic [3:0]          dx;
  logic [3:0]          dy;
  logic [PosWidth-1:0] sx;
  logic [PosWidth-1:0] sy;

  always_comb begin
    base_x = pos_x_word[PosWidth-1:0];
    base_y = pos_y_word[PosWidth-1:0];
    if (attr_word[15]) begin
      base_x = base_x + h_offset;
      base_y = base_y + v_offset;
    end
  end

  always_comb begin
    unique case (attr_word[14:12])
      ROT_NONE:    begin rot_x = pat_x;  rot_y = pat_y;  end
      ROT_FLIP_V:  begin rot_x = pat_x;  rot_y = ~pat_y; end
      ROT_FLIP_H:  begin rot_x = ~pat_x; rot_y = pat_y;  end
      ROT_FLIP_HV: begin rot_x = ~pat_x; rot_y = ~pat_y; end
      ROT_SWAP:    begin rot_x = pat_y;  rot_y = pat_x;  end
      ROT_SWAP_V:  begin rot_x = pat_y;  rot_y = ~pat_x; end
      ROT_SWAP_H:  begin rot_x = ~pat_y; rot_y = pat_x;  end
      ROT_SWAP_HV: begin rot_x = ~pat_y; rot_y = ~pat_x; end
      default:     begin rot_x = pat_x;  rot_y = pat_y;  end
    endcase
  end

  // Half-size shrinks act after the rotate.
  assign dx = attr_word[10] ? {1'b0, rot_x[3:1]} : rot_x;
  assign dy = attr_word[11] ? {1'b0, rot_y[3:1]} : rot_y;

  assign sx = base_x + {5'd0, dx};
  assign sy = base_y + {5'd0, dy};

  always_comb begin
    geom.visible      = !palette_word[13] && !sx[8] && !sy[8] && (sy >= MinRow);
    geom.palette_mode = palette_word[15];
    geom.spys         = palette_word[12];
    geom.vram_addr    = {sy[7:0], sx[7:0]};
    geom.pal_index    = palette_word[11:0];
    geom.nibble       = pat_x[1:0];
    if (palette_word[15]) begin
      // Four pixels per word, 64 words per pattern.
      geom.fetch_addr = {attr_word[9:0], pat_y, pat_x[3:2]};
    end else begin
      // One colour per word, 256 words over four pattern slots.
      geom.fetch_addr = {attr_word[9:2], pat_y, pat_x};
    end
  end

endmodule
`default_nettype wire

// ----- rtl/sprite_pixel_renderer_unit.sv -----
`default_nettype none
// ============================================================================
// Sprite pixel renderer
// Sprite RAM holder and per-pixel renderer that emits VRAM word writes.
// ============================================================================
// Usage: requests enter on the in channel (in_valid, in_stall). A write request
// (opcode 0) stores ram_data at ram_address of the 64K-word sprite RAM. A draw
// request (opcode 1) renders one pattern pixel of one sprite and gives at most
// one result on the out channel (out_valid, out_stall): a VRAM word address and
// colour. Hidden, clipped and transparent pixels give no result.
// Sequence: a write request, or a draw request that is hidden or clipped, needs
// no sprite RAM read and leaves the block idle. A direct-colour draw makes one
// sprite RAM read; a palette draw reads the pixel, then the palette entry if
// the pixel is not zero. The last RAM read data is loaded into the output
// register, which drives the out channel. The single read port of the sprite
// RAM sets this order; in_stall is high while a draw request is still fetching.
// The result sits in an output register, so the block takes the next request
// while a finished result waits. If the receiver stalls and a new result is
// ready, the block holds its RAM read data and stalls its input until the
// output register frees up.
// Reset clears the offset registers, the control state and the output valid.
// Sprite RAM content is undefined until written; no clearing pass is run.
// h_offset and v_offset are written through cfg_write, cfg_index, cfg_data.
// ============================================================================
module sprite_pixel_renderer_unit
  import spr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  // configuration
  input  wire logic                    cfg_write,
  input  wire logic                    cfg_index,
  input  wire logic [PosWidth-1:0]     cfg_data,
  // request channel
  input  wire logic                    in_valid,
  output      logic                    in_stall,
  input  wire logic                    opcode,
  input  wire logic [RamAddrWidth-1:0] ram_address,
  input  wire logic [RamDataWidth-1:0] ram_data,
  input  wire logic [15:0]             pos_x_word,
  input  wire logic [15:0]             pos_y_word,
  input  wire logic [15:0]             attr_word,
  input  wire logic [15:0]             palette_word,
  input  wire logic [3:0]              pat_x,
  input  wire logic [3:0]              pat_y,
  // result channel
  output      logic                    out_valid,
  input  wire logic                    out_stall,
  output      logic [15:0]             vram_address,
  output      logic [15:0]             vram_data
);

  spr_state_t state;
  spr_state_t state_next;

  logic [PosWidth-1:0] h_offset;
  logic [PosWidth-1:0] v_offset;

  spr_geom_t geom;

  // Per-request context held while fetching
  logic                    hold_palette;
  logic                    hold_spys;
  logic [RamAddrWidth-1:0] hold_vram_addr;
  logic [11:0]             hold_pal_index;
  logic [1:0]              hold_nibble;

  logic                    accept;
  logic                    ram_we;
  logic                    ram_re;
  logic [RamAddrWidth-1:0] ram_raddr;
  logic [RamDataWidth-1:0] ram_rdata;
  logic [3:0]              pixel;
  logic                    result_valid;
  logic                    out_free;
  logic                    out_load;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign out_load = result_valid && out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h_offset <= '0;
      v_offset <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_H_OFFSET: h_offset <= cfg_data;
        REG_V_OFFSET: v_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  spr_geom u_geom (
    .pos_x_word   (pos_x_word),
    .pos_y_word   (pos_y_word),
    .attr_word    (attr_word),
    .palette_word (palette_word),
    .pat_x        (pat_x),
    .pat_y        (pat_y),
    .h_offset     (h_offset),
    .v_offset     (v_offset),
    .geom         (geom)
  );

  spr_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_address),
    .wdata (ram_data),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Pick the pixel nibble out of the fetched pattern word, low nibble first.
  always_comb begin
    case (hold_nibble)
      2'd0:    pixel = ram_rdata[3:0];
      2'd1:    pixel = ram_rdata[7:4];
      2'd2:    pixel = ram_rdata[11:8];
      default: pixel = ram_rdata[15:12];
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (opcode == OP_DRAW) && geom.visible) begin
          state_next = ST_PIXEL;
        end
      end
      ST_PIXEL: begin
        if (hold_palette) begin
          state_next = (pixel == 4'd0) ? ST_IDLE : ST_COLOUR;
        end else if (ram_rdata[15] || out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_COLOUR: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall     = 1'b1;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_raddr    = geom.fetch_addr;
    result_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        ram_we   = accept && (opcode == OP_WRITE);
        ram_re   = accept && (opcode == OP_DRAW) && geom.visible;
      end
      ST_PIXEL: begin
        // The palette read is issued once; the colour state never re-reads.
        ram_raddr    = {hold_pal_index, pixel};
        ram_re       = hold_palette && (pixel != 4'd0);
        result_valid = !hold_palette && !ram_rdata[15];
      end
      ST_COLOUR: begin
        result_valid = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      hold_palette   <= geom.palette_mode;
      hold_spys      <= geom.spys;
      hold_vram_addr <= geom.vram_addr;
      hold_pal_index <= geom.pal_index;
      hold_nibble    <= geom.nibble;
    end
  end

  // Output register. Bit 15 of either colour is replaced by SPYS; a direct
  // colour that reaches here already has bit 15 clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      vram_address <= hold_vram_addr;
      vram_data    <= {hold_spys, ram_rdata[14:0]};
    end
  end

  // The sprite RAM is never written and read in the same cycle.
  assert property (@(posedge clk) disable iff (rst) !(ram_we && ram_re))
    else $error("sprite RAM write and read in the same cycle");

  // A draw request that is hidden or clipped leaves the block idle.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (opcode == OP_DRAW) && !geom.visible) |=> (state == ST_IDLE))
    else $error("rejected draw request left the idle state");

  // A result loaded into the output register is presented next cycle.
  assert property (@(posedge clk) disable iff (rst) out_load |=> out_valid)
    else $error("loaded result not presented");

endmodule
`default_nettype wire

// ----- test/sprite_pixel_renderer_unit_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Sprite pixel renderer testbench
// Drives sprite RAM writes and pixel draws through the request channel and
// checks every VRAM word write against an in-bench prediction of the block.
// ============================================================================
module sprite_pixel_renderer_unit_test;
  import spr_pkg::*;

  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_QUOTA    = 160;

  // One request as it sits on the request channel.
  typedef struct packed {
    logic        opcode;
    logic [15:0] ram_address;
    logic [15:0] ram_data;
    logic [15:0] pos_x_word;
    logic [15:0] pos_y_word;
    logic [15:0] attr_word;
    logic [15:0] palette_word;
    logic [3:0]  pat_x;
    logic [3:0]  pat_y;
  } pix_req_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [15:0] data;
  } vram_write_t;

  // How a directed row is checked: by the predictor, as giving no result, or
  // against the value typed into the row.
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_SILENT,
    CHK_TYPED
  } row_check_t;

  typedef struct {
    pix_req_t    req;
    row_check_t  chk;
    vram_write_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  logic                    cfg_write;
  logic                    cfg_index;
  logic [PosWidth-1:0]     cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic                    opcode;
  logic [RamAddrWidth-1:0] ram_address;
  logic [RamDataWidth-1:0] ram_data;
  logic [15:0]             pos_x_word;
  logic [15:0]             pos_y_word;
  logic [15:0]             attr_word;
  logic [15:0]             palette_word;
  logic [3:0]              pat_x;
  logic [3:0]              pat_y;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [15:0]             vram_address;
  logic [15:0]             vram_data;

  sprite_pixel_renderer_unit uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .ram_address  (ram_address),
    .ram_data     (ram_data),
    .pos_x_word   (pos_x_word),
    .pos_y_word   (pos_y_word),
    .attr_word    (attr_word),
    .palette_word (palette_word),
    .pat_x        (pat_x),
    .pat_y        (pat_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vram_address (vram_address),
    .vram_data    (vram_data)
  );

  always #1 clk = ~clk;

  // Shadow of the block: sprite RAM contents, which words have been written
  // so far, and the two offset registers.
  logic [15:0]   ram_model [0:65535];
  bit            ram_written [0:65535];
  logic [8:0]    cur_h_offset;
  logic [8:0]    cur_v_offset;

  vram_write_t   vram_writes_q [$];
  vram_write_t   head_write;
  stim_row_t     directed_rows [$];
  int            mismatch_count = 0;
  int            quiet_cycles = 0;
  int            sent_count = 0;

  // Receiver stall pattern state.
  int            stall_mode = 0;
  int            stall_left = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  function automatic void add_expected(input vram_write_t w);
    vram_writes_q.insert(vram_writes_q.size(), w);
  endfunction

  function automatic void add_row(input stim_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Geometry of one draw request: whether it lands on screen at all (not
  // hidden, not clipped), the VRAM word it lands on, and the sprite RAM word
  // that holds its pattern pixel.
  function automatic void locate_pixel(input pix_req_t r, output bit shown,
                                       output logic [15:0] vaddr,
                                       output logic [15:0] src);
    logic [8:0] x, y, sx, sy;
    logic [3:0] dx, dy;
    logic [9:0] pat;
    x = r.pos_x_word[8:0];
    y = r.pos_y_word[8:0];
    if (r.attr_word[15]) begin
      x = x + cur_h_offset;
      y = y + cur_v_offset;
    end
    case (r.attr_word[14:12])
      ROT_NONE: begin
        dx = r.pat_x;          dy = r.pat_y;
      end
      ROT_FLIP_V: begin
        dx = r.pat_x;          dy = 4'd15 - r.pat_y;
      end
      ROT_FLIP_H: begin
        dx = 4'd15 - r.pat_x;  dy = r.pat_y;
      end
      ROT_FLIP_HV: begin
        dx = 4'd15 - r.pat_x;  dy = 4'd15 - r.pat_y;
      end
      ROT_SWAP: begin
        dx = r.pat_y;          dy = r.pat_x;
      end
      ROT_SWAP_V: begin
        dx = r.pat_y;          dy = 4'd15 - r.pat_x;
      end
      ROT_SWAP_H: begin
        dx = 4'd15 - r.pat_y;  dy = r.pat_x;
      end
      default: begin
        dx = 4'd15 - r.pat_y;  dy = 4'd15 - r.pat_x;
      end
    endcase
    // The shrink bits halve the offset inside the sprite after rotation.
    if (r.attr_word[10])
      dx = dx >> 1;
    if (r.attr_word[11])
      dy = dy >> 1;
    sx = x + {5'd0, dx};
    sy = y + {5'd0, dy};
    shown = !r.palette_word[13] && !sx[8] && !sy[8] && (sy >= MinRow);
    vaddr = {sy[7:0], sx[7:0]};
    pat = r.attr_word[9:0];
    // Palette patterns pack four pixels per word; direct patterns use one
    // word per pixel and span four pattern slots.
    if (r.palette_word[15])
      src = {pat, r.pat_y, r.pat_x[3:2]};
    else
      src = {pat[9:2], r.pat_y, r.pat_x};
  endfunction

  // Applies one accepted request to the shadow state and says whether it
  // gives a VRAM write, and which.
  function automatic bit render_pixel(input pix_req_t r, output vram_write_t w);
    bit          shown;
    logic [15:0] vaddr, src, word, shifted, colour;
    logic [3:0]  pix;
    w = '0;
    if (r.opcode == OP_WRITE) begin
      ram_model[r.ram_address] = r.ram_data;
      ram_written[r.ram_address] = 1'b1;
      return 1'b0;
    end
    locate_pixel(r, shown, vaddr, src);
    if (!shown)
      return 1'b0;
    word = ram_model[src];
    if (r.palette_word[15]) begin
      shifted = word >> {r.pat_x[1:0], 2'b00};
      pix = shifted[3:0];
      // Pixel value zero is see-through in palette mode.
      if (pix == 4'd0)
        return 1'b0;
      colour = ram_model[{r.palette_word[11:0], pix}];
    end else begin
      // A direct colour with its top bit set is see-through.
      if (word[15])
        return 1'b0;
      colour = word;
    end
    // The palette entry's top bit is dropped; SPYS takes its place.
    w.addr = vaddr;
    w.data = {r.palette_word[12], colour[14:0]};
    return 1'b1;
  endfunction

  // Presents one request, holds it until the block takes it, and files the
  // expected VRAM write, if any.
  task automatic send_request(input pix_req_t r, input row_check_t chk,
                              input vram_write_t typed);
    vram_write_t w;
    bit          hit;
    @(negedge clk);
    opcode       <= r.opcode;
    ram_address  <= r.ram_address;
    ram_data     <= r.ram_data;
    pos_x_word   <= r.pos_x_word;
    pos_y_word   <= r.pos_y_word;
    attr_word    <= r.attr_word;
    palette_word <= r.palette_word;
    pat_x        <= r.pat_x;
    pat_y        <= r.pat_y;
    in_valid     <= 1'b1;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    sent_count++;
    hit = render_pixel(r, w);
    case (chk)
      CHK_TYPED:  add_expected(typed);
      CHK_SILENT: ;
      default: begin
        if (hit)
          add_expected(w);
      end
    endcase
  endtask

  task automatic send_write(input logic [15:0] addr, input logic [15:0] data);
    pix_req_t r;
    r.opcode       = OP_WRITE;
    r.ram_address  = addr;
    r.ram_data     = data;
    r.pos_x_word   = 16'($urandom);
    r.pos_y_word   = 16'($urandom);
    r.attr_word    = 16'($urandom);
    r.palette_word = 16'($urandom);
    r.pat_x        = 4'($urandom);
    r.pat_y        = 4'($urandom);
    send_request(r, CHK_MODEL, '0);
  endtask

  // Sprite RAM is undefined until written, so before a draw goes out every
  // word it will read is given a value first. The palette word depends on
  // the pixel value, which is known only once the pattern word is in place.
  task automatic prime_draw(input pix_req_t r);
    bit          shown;
    logic [15:0] vaddr, src, shifted, pal_addr;
    logic [3:0]  pix;
    locate_pixel(r, shown, vaddr, src);
    if (!shown)
      return;
    if (!ram_written[src])
      send_write(src, 16'($urandom));
    if (r.palette_word[15]) begin
      shifted = ram_model[src] >> {r.pat_x[1:0], 2'b00};
      pix = shifted[3:0];
      pal_addr = {r.palette_word[11:0], pix};
      if (pix != 4'd0 && !ram_written[pal_addr])
        send_write(pal_addr, 16'($urandom));
    end
  endtask

  // Lowers valid; the next request goes out once the wait given by n is over.
  task automatic idle_input(input int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1)
      @(negedge clk);
  endtask

  task automatic wait_drained();
    while (vram_writes_q.size() != 0)
      @(posedge clk);
  endtask

  // Stops the sender and waits for every result, then gives a request that
  // makes no result time to finish inside the block.
  task automatic settle_block();
    idle_input(1);
    wait_drained();
    repeat (SETTLE_CYCLES)
      @(posedge clk);
  endtask

  task automatic write_offset(input logic idx, input logic [8:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_H_OFFSET)
      cur_h_offset = val;
    else
      cur_v_offset = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic stim_row_t write_row(input logic [15:0] addr,
                                          input logic [15:0] data);
    stim_row_t row;
    row.req = '0;
    row.req.opcode = OP_WRITE;
    row.req.ram_address = addr;
    row.req.ram_data = data;
    row.chk = CHK_SILENT;
    row.want = '0;
    return row;
  endfunction

  function automatic stim_row_t draw_row(input logic [15:0] x, y, attr, pal,
                                         input logic [3:0] px, py,
                                         input row_check_t chk,
                                         input logic [15:0] waddr, wdata);
    stim_row_t row;
    row.req.opcode       = OP_DRAW;
    row.req.ram_address  = '0;
    row.req.ram_data     = '0;
    row.req.pos_x_word   = x;
    row.req.pos_y_word   = y;
    row.req.attr_word    = attr;
    row.req.palette_word = pal;
    row.req.pat_x        = px;
    row.req.pat_y        = py;
    row.chk              = chk;
    row.want.addr        = waddr;
    row.want.data        = wdata;
    return row;
  endfunction

  // A random request. Most draws stay on screen and use a small pool of
  // patterns and palettes at both ends of the RAM, so that words get read
  // back and overwritten; the rest spread over the full field ranges.
  function automatic pix_req_t random_request();
    pix_req_t r;
    int       kind;
    r.ram_address  = 16'($urandom);
    r.ram_data     = 16'($urandom);
    r.pos_x_word   = 16'($urandom);
    r.pos_y_word   = 16'($urandom);
    r.attr_word    = 16'($urandom);
    r.palette_word = 16'($urandom);
    r.pat_x        = 4'($urandom);
    r.pat_y        = 4'($urandom);
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      r.opcode = OP_WRITE;
      if (kind >= 4)
        r.ram_address = $urandom_range(0, 1) ? 16'($urandom_range(0, 511))
                                             : 16'($urandom_range(16'hfe00, 16'hffff));
    end else begin
      r.opcode = OP_DRAW;
      if ($urandom_range(0, 3) != 0)
        r.pos_x_word[8:0] = 9'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0)
        r.pos_y_word[8:0] = 9'($urandom_range(0, 255));
      if ($urandom_range(0, 4) != 0)
        r.attr_word[9:0] = $urandom_range(0, 1) ? 10'($urandom_range(0, 7))
                                                : 10'($urandom_range(1016, 1023));
      if ($urandom_range(0, 4) != 0)
        r.palette_word[11:0] = $urandom_range(0, 1) ? 12'($urandom_range(0, 3))
                                                    : 12'($urandom_range(4092, 4095));
      r.palette_word[13] = ($urandom_range(0, 7) == 0);
    end
    return r;
  endfunction

  // One random phase: bursts of back-to-back requests with gaps between
  // them, and now and then a full pause until all results are back. Every
  // request sent, the priming writes included, counts toward the quota.
  task automatic run_random_phase(input int quota);
    pix_req_t    r;
    int          first;
    int          burst_left;
    int          gap;
    first = sent_count;
    burst_left = 0;
    while (sent_count - first < quota) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0)
          idle_input(gap);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      if ($urandom_range(0, 99) == 0) begin
        idle_input(1);
        wait_drained();
      end
      r = random_request();
      if (r.opcode == OP_DRAW)
        prime_draw(r);
      send_request(r, CHK_MODEL, '0);
    end
  endtask

  // Receiver: stretches whose length is drawn at random, each with its own stall
  // behavior (never, light, heavy, or a fixed pulse train).
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end else begin
      stall_left = stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((stall_left % 8) < 3);
    endcase
  end

  // Every result the block hands over must match the oldest expected write.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (vram_writes_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: addr %h data %h",
                                  vram_address, vram_data));
      end else begin
        head_write = vram_writes_q.pop_front();
        if (vram_address !== head_write.addr)
          report_mismatch($sformatf("vram_address %h, expected %h",
                                    vram_address, head_write.addr));
        if (vram_data !== head_write.data)
          report_mismatch($sformatf("vram_data %h, expected %h at %h",
                                    vram_data, head_write.data, head_write.addr));
      end
    end
  end

  // Watchdog: the run is stuck if neither channel moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sprite_pixel_renderer_unit_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [8:0] h_plan [0:4];
    logic [8:0] v_plan [0:4];

    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_H_OFFSET;
    cfg_data     = '0;
    in_valid     = 1'b0;
    opcode       = OP_WRITE;
    ram_address  = '0;
    ram_data     = '0;
    pos_x_word   = '0;
    pos_y_word   = '0;
    attr_word    = '0;
    palette_word = '0;
    pat_x        = '0;
    pat_y        = '0;
    cur_h_offset = '0;
    cur_v_offset = '0;

    // Offset settings per phase; phase 0 runs on the reset values.
    h_plan[0] = 9'd0;    v_plan[0] = 9'd0;
    h_plan[1] = 9'd511;  v_plan[1] = 9'd511;
    h_plan[2] = 9'($urandom); v_plan[2] = 9'($urandom);
    h_plan[3] = 9'd256;  v_plan[3] = 9'd254;
    h_plan[4] = 9'd0;    v_plan[4] = 9'd0;

    // Directed table. Pattern 0 (palette mode) row 0 holds pixels 1, 15, 0,
    // 0; palette 0x100 has entry 1 all ones and entry 15 zero. Pattern 4
    // (direct) has a plain colour at (0,0), a see-through one at (15,15) and
    // 0x1234 at (0,1). The last word of pattern 1023 holds pixel 1 at x=15.
    add_row(write_row(16'h0000, 16'h00f1));
    add_row(write_row(16'h1001, 16'hffff));
    add_row(write_row(16'h100f, 16'h0000));
    add_row(write_row(16'h0100, 16'h7fff));
    add_row(write_row(16'h01ff, 16'h8000));
    add_row(write_row(16'h0110, 16'h1234));
    add_row(write_row(16'hffff, 16'h1000));
    // Palette mode: unused position bits set, top colour bit dropped.
    add_row(draw_row(16'hfe00, 16'hfe02, 16'h0000, 16'h8100, 4'd0, 4'd0,
                     CHK_TYPED, 16'h0200, 16'h7fff));
    // SPYS fills the top colour bit.
    add_row(draw_row(16'h0000, 16'h0002, 16'h0000, 16'h9100, 4'd0, 4'd0,
                     CHK_TYPED, 16'h0200, 16'hffff));
    // A palette colour of zero is still drawn.
    add_row(draw_row(16'h0000, 16'h0002, 16'h0000, 16'h8100, 4'd1, 4'd0,
                     CHK_TYPED, 16'h0201, 16'h0000));
    // Palette pixel zero is see-through.
    add_row(draw_row(16'h0000, 16'h0002, 16'h0000, 16'h8100, 4'd2, 4'd0,
                     CHK_SILENT, '0, '0));
    // Hidden sprite.
    add_row(draw_row(16'h0000, 16'h0002, 16'h0000, 16'he100, 4'd0, 4'd0,
                     CHK_SILENT, '0, '0));
    // Clipped above the first visible row, below the screen, and to the right of the screen.
    add_row(draw_row(16'h0000, 16'h0001, 16'h0000, 16'h8100, 4'd0, 4'd0,
                     CHK_SILENT, '0, '0));
    add_row(draw_row(16'h0000, 16'h0100, 16'h0000, 16'h8100, 4'd0, 4'd0,
                     CHK_SILENT, '0, '0));
    add_row(draw_row(16'h0100, 16'h0002, 16'h0000, 16'h8100, 4'd0, 4'd0,
                     CHK_SILENT, '0, '0));
    // x wraps past 511 back onto the screen.
    add_row(draw_row(16'h01ff, 16'h0002, 16'h0000, 16'h8100, 4'd1, 4'd0,
                     CHK_TYPED, 16'h0200, 16'h0000));
    // Bottom right corner of the screen.
    add_row(draw_row(16'h00ff, 16'h00ff, 16'h0000, 16'h8100, 4'd0, 4'd0,
                     CHK_TYPED, 16'hffff, 16'h7fff));
    // Direct mode: the pattern number loses its low two bits.
    add_row(draw_row(16'h000a, 16'h0014, 16'h0007, 16'h0000, 4'd0, 4'd0,
                     CHK_TYPED, 16'h140a, 16'h7fff));
    add_row(draw_row(16'h000a, 16'h0014, 16'h0007, 16'h0000, 4'd15, 4'd15,
                     CHK_SILENT, '0, '0));
    add_row(draw_row(16'h000a, 16'h0014, 16'h0004, 16'h1000, 4'd0, 4'd1,
                     CHK_TYPED, 16'h150a, 16'h9234));
    // All eight rotate and flip modes, with shrinks and the offset bit.
    add_row(draw_row(16'd100, 16'd100, 16'h0004, 16'h0000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'h1004, 16'h4000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'h2404, 16'h0000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'h3c04, 16'h1000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'h4004, 16'h0000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'h5804, 16'h4000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'h6404, 16'h0000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    add_row(draw_row(16'd100, 16'd100, 16'hf804, 16'h1000, 4'd0, 4'd1,
                     CHK_MODEL, '0, '0));
    // Highest pattern number, plain and with every attribute bit set.
    add_row(draw_row(16'h0000, 16'h0002, 16'h03ff, 16'h8100, 4'd15, 4'd15,
                     CHK_TYPED, 16'h110f, 16'h7fff));
    add_row(draw_row(16'h0000, 16'h0002, 16'hffff, 16'h8100, 4'd15, 4'd15,
                     CHK_MODEL, '0, '0));

    repeat (2)
      @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      if (p == 0) begin
        foreach (directed_rows[i]) begin
          if ($urandom_range(0, 2) == 0)
            idle_input($urandom_range(1, 3));
          if (directed_rows[i].req.opcode == OP_DRAW)
            prime_draw(directed_rows[i].req);
          send_request(directed_rows[i].req, directed_rows[i].chk,
                       directed_rows[i].want);
        end
      end else begin
        // Offsets change only with the block idle and every result back.
        settle_block();
        write_offset(REG_H_OFFSET, h_plan[p]);
        write_offset(REG_V_OFFSET, v_plan[p]);
      end
      run_random_phase(PHASE_QUOTA);
    end

    settle_block();
    if (vram_writes_q.size() != 0)
      report_mismatch($sformatf("%0d expected results never arrived",
                                vram_writes_q.size()));
    if (mismatch_count == 0)
      $display("sprite_pixel_renderer_unit_test: done, clean");
    else
      $display("sprite_pixel_renderer_unit_test: done, errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/spr_pkg.sv
rtl/spr_ram.sv
rtl/spr_geom.sv
rtl/sprite_pixel_renderer_unit.sv
test/sprite_pixel_renderer_unit_test.sv
